>>> sv/vag_pkg.sv
// ----------------------------------------------------------------------------
// vag_pkg
// Types and constants shared by the voice activity gate modules.
// ----------------------------------------------------------------------------
package vag_pkg;

    typedef enum logic [1:0] {
        OP_CAPTURE        = 2'd0,
        OP_ARM            = 2'd1,
        OP_BREAK          = 2'd2,
        OP_LISTENER_RESET = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CFG_MIN_START_LEVEL = 3'd0,
        CFG_START_FRAMES    = 3'd1,
        CFG_END_FRAMES      = 3'd2,
        CFG_WARMUP_FRAMES   = 3'd3,
        CFG_TAIL_FRAMES     = 3'd4,
        CFG_REF_WAIT_LIMIT  = 3'd5
    } t_cfg_idx;

    localparam int CFG_DATA_W = 11;

    localparam logic        [5:0]  RUN_MAX     = 6'd63;
    localparam logic        [7:0]  WAIT_MAX    = 8'd255;
    localparam logic signed [11:0] LEVEL_FLOOR = -12'sd1200;

    typedef struct packed {
        logic signed [10:0] min_start_level;
        logic [5:0]         start_frames;
        logic [5:0]         end_frames;
        logic [5:0]         warmup_frames;
        logic [5:0]         tail_frames;
        logic [7:0]         reference_wait_limit;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        min_start_level:      -11'sd400,
        start_frames:         6'd6,
        end_frames:           6'd35,
        warmup_frames:        6'd30,
        tail_frames:          6'd15,
        reference_wait_limit: 8'd50
    };

    typedef struct packed {
        t_op                operation;
        logic               voice_detected;
        logic signed [11:0] mic_level;
        logic               reference_now;
        logic               play_done;
        logic               play_cut;
        logic               render_started;
        logic               output_audible;
    } t_in_item;

    typedef struct packed {
        logic               is_break;
        logic               vad_now;
        logic               speech_start;
        logic               speech_stop;
        logic               voice_pass;
        logic               ref_seen;
        logic signed [11:0] input_level;
        logic               vad_history_reset;
        logic               reference_absent_warn;
    } t_out_item;

endpackage

>>> sv/vag_cfg.sv
// ----------------------------------------------------------------------------
// vag_cfg
// Configuration register file, written one register per beat.
// ----------------------------------------------------------------------------
module vag_cfg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [2:0]            i_cfg_index,
    input  logic [10:0]           i_cfg_data,
    output logic                  o_cfg_ready,
    output vag_pkg::t_cfg         o_cfg
);
    import vag_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_START_LEVEL: n_cfg.min_start_level      = $signed(i_cfg_data);
                CFG_START_FRAMES:    n_cfg.start_frames         = i_cfg_data[5:0];
                CFG_END_FRAMES:      n_cfg.end_frames           = i_cfg_data[5:0];
                CFG_WARMUP_FRAMES:   n_cfg.warmup_frames        = i_cfg_data[5:0];
                CFG_TAIL_FRAMES:     n_cfg.tail_frames          = i_cfg_data[5:0];
                CFG_REF_WAIT_LIMIT:  n_cfg.reference_wait_limit = i_cfg_data[7:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> sv/vag_core.sv
// ----------------------------------------------------------------------------
// vag_core
// Speech run tracking and playback gate state, one frame per advance.
// ----------------------------------------------------------------------------
module vag_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  vag_pkg::t_in_item     i_item,
    input  vag_pkg::t_cfg         i_cfg,
    output logic                  o_has_result,
    output vag_pkg::t_out_item    o_result
);
    import vag_pkg::*;

    logic               r_in_speech,      n_in_speech;
    logic [5:0]         r_voiced_run,     n_voiced_run;
    logic [5:0]         r_silent_run,     n_silent_run;
    logic               r_session_active, n_session_active;
    logic               r_warmup_armed,   n_warmup_armed;
    logic               r_silent_bypass,  n_silent_bypass;
    logic [5:0]         r_warmup_left,    n_warmup_left;
    logic [5:0]         r_tail_left,      n_tail_left;
    logic [7:0]         r_wait_count,     n_wait_count;
    logic signed [11:0] r_dlevel,         n_dlevel;
    logic               r_dref,           n_dref;

    logic admitted;
    logic vad_now;
    logic started;
    logic vend;
    logic suppress;
    logic reset_vad;
    logic warn;
    logic signed [11:0] min_level;

    assign min_level = {i_cfg.min_start_level[10], i_cfg.min_start_level};

    always_comb begin
        n_in_speech      = r_in_speech;
        n_voiced_run     = r_voiced_run;
        n_silent_run     = r_silent_run;
        n_session_active = r_session_active;
        n_warmup_armed   = r_warmup_armed;
        n_silent_bypass  = r_silent_bypass;
        n_warmup_left    = r_warmup_left;
        n_tail_left      = r_tail_left;
        n_wait_count     = r_wait_count;
        n_dlevel         = r_dlevel;
        n_dref           = r_dref;
        admitted         = 1'b0;
        vad_now          = 1'b0;
        started          = 1'b0;
        vend             = 1'b0;
        suppress         = 1'b0;
        reset_vad        = 1'b0;
        warn             = 1'b0;
        o_has_result     = 1'b0;
        o_result         = '0;

        if (i_advance) begin
            unique case (i_item.operation)
                OP_ARM: begin
                    n_session_active = 1'b1;
                    n_warmup_armed   = 1'b1;
                    n_silent_bypass  = 1'b0;
                    n_warmup_left    = '0;
                    n_wait_count     = '0;
                    n_tail_left      = '0;
                end
                OP_LISTENER_RESET: begin
                    n_in_speech  = 1'b0;
                    n_voiced_run = '0;
                    n_silent_run = '0;
                end
                OP_BREAK: begin
                    if (r_session_active) begin
                        n_warmup_armed = 1'b1;
                        n_warmup_left  = '0;
                    end
                    n_dlevel                   = LEVEL_FLOOR;
                    n_dref                     = 1'b0;
                    n_in_speech                = 1'b0;
                    n_voiced_run               = '0;
                    n_silent_run               = '0;
                    o_has_result               = 1'b1;
                    o_result.is_break          = 1'b1;
                    o_result.vad_history_reset = 1'b1;
                end
                OP_CAPTURE: begin
                    n_dref   = i_item.reference_now;
                    admitted = r_in_speech || (r_dlevel >= min_level);
                    vad_now  = i_item.voice_detected && admitted;
                    if (vad_now) begin
                        if (r_voiced_run < RUN_MAX) n_voiced_run = 6'(r_voiced_run + 6'd1);
                        n_silent_run = '0;
                    end else begin
                        if (r_silent_run < RUN_MAX) n_silent_run = 6'(r_silent_run + 6'd1);
                        n_voiced_run = '0;
                    end
                    if (!r_in_speech && n_voiced_run >= i_cfg.start_frames) begin
                        n_in_speech = 1'b1;
                        started     = 1'b1;
                    end else if (r_in_speech && n_silent_run >= i_cfg.end_frames) begin
                        n_in_speech = 1'b0;
                        vend        = 1'b1;
                    end
                    n_dlevel = i_item.mic_level;

                    if (i_item.play_done) begin
                        n_session_active = 1'b0;
                        n_warmup_armed   = 1'b0;
                        n_silent_bypass  = 1'b0;
                        n_warmup_left    = '0;
                        if (i_item.play_cut) begin
                            n_tail_left = '0;
                        end else begin
                            n_tail_left = i_cfg.tail_frames;
                            suppress    = 1'b1;
                        end
                    end else if (r_silent_bypass && i_item.output_audible) begin
                        n_silent_bypass = 1'b0;
                        n_warmup_armed  = 1'b1;
                        n_wait_count    = '0;
                        suppress        = 1'b1;
                    end else if (r_warmup_armed) begin
                        suppress = 1'b1;
                        if (!i_item.render_started) begin
                            n_wait_count = '0;
                        end else if (!i_item.output_audible) begin
                            n_warmup_armed  = 1'b0;
                            n_silent_bypass = 1'b1;
                            n_wait_count    = '0;
                            suppress        = 1'b0;
                        end else if (r_dref) begin
                            n_warmup_armed = 1'b0;
                            n_warmup_left  = i_cfg.warmup_frames;
                            n_wait_count   = '0;
                        end else if (r_wait_count < WAIT_MAX) begin
                            n_wait_count = 8'(r_wait_count + 8'd1);
                            warn = (n_wait_count == i_cfg.reference_wait_limit);
                        end
                    end

                    if (n_warmup_left != '0) begin
                        suppress      = 1'b1;
                        n_warmup_left = 6'(n_warmup_left - 6'd1);
                        if (n_warmup_left == '0) reset_vad = 1'b1;
                    end
                    if (n_tail_left != '0) begin
                        suppress    = 1'b1;
                        n_tail_left = 6'(n_tail_left - 6'd1);
                        if (n_tail_left == '0) reset_vad = 1'b1;
                    end
                    if (reset_vad) begin
                        n_in_speech  = 1'b0;
                        n_voiced_run = '0;
                        n_silent_run = '0;
                    end

                    o_has_result                   = 1'b1;
                    o_result.vad_now               = vad_now;
                    o_result.speech_start          = started;
                    o_result.speech_stop           = vend;
                    o_result.voice_pass            = vad_now && !suppress;
                    o_result.ref_seen              = r_dref;
                    o_result.input_level           = r_dlevel;
                    o_result.vad_history_reset     = reset_vad;
                    o_result.reference_absent_warn = warn;
                end
                default: o_has_result = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_speech      <= 1'b0;
            r_voiced_run     <= '0;
            r_silent_run     <= '0;
            r_session_active <= 1'b0;
            r_warmup_armed   <= 1'b0;
            r_silent_bypass  <= 1'b0;
            r_warmup_left    <= '0;
            r_tail_left      <= '0;
            r_wait_count     <= '0;
            r_dlevel         <= LEVEL_FLOOR;
            r_dref           <= 1'b0;
        end else begin
            r_in_speech      <= n_in_speech;
            r_voiced_run     <= n_voiced_run;
            r_silent_run     <= n_silent_run;
            r_session_active <= n_session_active;
            r_warmup_armed   <= n_warmup_armed;
            r_silent_bypass  <= n_silent_bypass;
            r_warmup_left    <= n_warmup_left;
            r_tail_left      <= n_tail_left;
            r_wait_count     <= n_wait_count;
            r_dlevel         <= n_dlevel;
            r_dref           <= n_dref;
        end
    end

    a_break_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_item.operation == OP_BREAK
        |=> !r_in_speech && r_voiced_run == '0 && r_dlevel == LEVEL_FLOOR && !r_dref)
        else $error("break beat left speech or delay state behind");

    a_start_sets_speech: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_has_result && o_result.speech_start && !o_result.vad_history_reset
        |=> r_in_speech)
        else $error("speech start not recorded");

    a_arm_sets_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_item.operation == OP_ARM
        |=> r_session_active && r_warmup_armed && r_wait_count == '0 && r_tail_left == '0)
        else $error("arm beat did not arm the playback gate");

    a_no_result_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_has_result |-> i_advance
            && (i_item.operation == OP_CAPTURE || i_item.operation == OP_BREAK))
        else $error("result produced without a capture or break beat");

endmodule

>>> sv/voice_activity_gate.sv
// ----------------------------------------------------------------------------
// voice_activity_gate
// Per-frame speech start/end detection with a playback echo gate.
// ----------------------------------------------------------------------------
// Path: the input register, then the result register; a stalled result port holds both.
// Throughput: one input beat per cycle unless stalled; arm and listener-reset give no result.
// Each frame's state update is one pass of logic in the core between the two registers.
// Reset: synchronous, active low; clears state and loads register defaults.
module voice_activity_gate (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  vag_pkg::t_in_item     i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output vag_pkg::t_out_item    o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [10:0]           i_cfg_data
);
    import vag_pkg::*;

    logic      r_in_vld;
    t_in_item  r_in_item;
    logic      r_out_vld;
    t_out_item r_out_item;

    t_cfg      cfg;
    logic      advance;
    logic      out_free;
    logic      has_result;
    t_out_item result;

    assign out_free    = !r_out_vld || i_out_ready;
    assign advance     = r_in_vld && out_free;
    assign o_in_ready  = !r_in_vld || advance;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_item;

    vag_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    vag_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_item       (r_in_item),
        .i_cfg        (cfg),
        .o_has_result (has_result),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (out_free) begin
                r_out_vld <= advance && has_result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_data;
        end
        if (advance && has_result) begin
            r_out_item <= result;
        end
    end

endmodule

>>> tb/voice_activity_gate_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice_activity_gate_tb
// Self-checking bench for the voice activity gate. A short stimulus table
// covers level extremes, every operation, the playback gate path and the
// countdown expiries. Random frame streams follow: speech bursts, silences
// and playback sessions with arm, render, reference, bypass and end events,
// mixed with random noise beats. Register settings change between phases.
// The frame predictor, or a typed table row, gives the expected result of
// each result beat; the result port is compared field by field in order.
// ----------------------------------------------------------------------------
module voice_activity_gate_tb;
    import vag_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASES        = 9;

    localparam t_out_item OUT_AFTER_RESET = '{input_level: LEVEL_FLOOR, default: '0};
    localparam t_out_item OUT_BREAK = '{is_break: 1'b1, vad_history_reset: 1'b1, default: '0};

    typedef enum logic [2:0] {
        PB_IDLE, PB_PRE_RENDER, PB_MUTED, PB_AWAIT_REF, PB_PLAYING
    } t_pb_stage;

    typedef struct {
        t_op                op;
        logic               voice;
        logic signed [11:0] level;
        logic [4:0]         playback;
        bit                 typed;
        t_out_item          want;
    } t_frame_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_ready = 1'b0;
    logic      i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [10:0] i_cfg_data  = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      o_cfg_ready;

    voice_activity_gate uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // predictor state
    t_cfg               gate_cfg;
    logic               speaking, session_on, gate_armed, bypass_on, prev_ref;
    logic [5:0]         voiced_streak, quiet_streak, warmup_count, tail_count;
    logic [7:0]         ref_wait;
    logic signed [11:0] prev_level;

    t_out_item results_due[$];
    int        mismatches   = 0;
    int        cycle_count  = 0;
    int        tx_idle_pct  = 13;
    int        rx_idle_pct  = 85;
    int        rx_hold_req  = 0;
    int        rx_hold_left = 0;
    logic [10:0] reg_plan [6];

    int        speech_left = 0;
    int        quiet_left  = 0;
    int        pb_left     = 0;
    t_pb_stage pb_stage    = PB_IDLE;

    // playback bits: reference, ended, interrupted, rendered, audible
    t_frame_row directed_rows [25] = '{
        '{OP_CAPTURE,        1'b0,  12'sd0,    5'b00000, 1'b1, OUT_AFTER_RESET},
        '{OP_CAPTURE,        1'b1, -12'sd1200, 5'b00000, 1'b0, '0},
        '{OP_CAPTURE,        1'b1,  12'sd0,    5'b00000, 1'b0, '0},
        '{OP_CAPTURE,        1'b1, -12'sd400,  5'b00000, 1'b0, '0},
        '{OP_CAPTURE,        1'b1, -12'sd401,  5'b00000, 1'b0, '0},
        '{OP_CAPTURE,        1'b1, -12'sd1200, 5'b00000, 1'b0, '0},
        '{OP_CAPTURE,        1'b0, -12'sd1200, 5'b00000, 1'b0, '0},
        '{OP_CAPTURE,        1'b0, -12'sd1200, 5'b00000, 1'b0, '0},
        '{OP_BREAK,          1'b1,  12'sd0,    5'b11111, 1'b1, OUT_BREAK},
        '{OP_LISTENER_RESET, 1'b1,  12'sd0,    5'b11111, 1'b0, '0},
        '{OP_ARM,            1'b0, -12'sd1,    5'b00000, 1'b0, '0},
        '{OP_CAPTURE,        1'b1,  12'sd0,    5'b00000, 1'b0, '0},
        '{OP_CAPTURE,        1'b1,  12'sd0,    5'b00011, 1'b0, '0},
        '{OP_CAPTURE,        1'b1,  12'sd0,    5'b00011, 1'b0, '0},
        '{OP_CAPTURE,        1'b1,  12'sd0,    5'b10011, 1'b0, '0},
        '{OP_CAPTURE,        1'b1,  12'sd0,    5'b10011, 1'b0, '0},
        '{OP_CAPTURE,        1'b1,  12'sd0,    5'b00011, 1'b0, '0},
        '{OP_BREAK,          1'b0, -12'sd1200, 5'b00000, 1'b1, OUT_BREAK},
        '{OP_CAPTURE,        1'b1,  12'sd0,    5'b00010, 1'b0, '0},
        '{OP_CAPTURE,        1'b1,  12'sd0,    5'b00011, 1'b0, '0},
        '{OP_CAPTURE,        1'b1,  12'sd0,    5'b01000, 1'b0, '0},
        '{OP_CAPTURE,        1'b1,  12'sd0,    5'b00000, 1'b0, '0},
        '{OP_CAPTURE,        1'b1,  12'sh7FF,  5'b01100, 1'b0, '0},
        '{OP_CAPTURE,        1'b1,  12'sh800,  5'b00000, 1'b0, '0},
        '{OP_CAPTURE,        1'b0, -12'sd1,    5'b00000, 1'b0, '0}
    };

    function automatic void clear_speech();
        speaking      = 1'b0;
        voiced_streak = '0;
        quiet_streak  = '0;
    endfunction

    function automatic void reset_gate_model();
        gate_cfg     = CFG_RESET;
        clear_speech();
        session_on   = 1'b0;
        gate_armed   = 1'b0;
        bypass_on    = 1'b0;
        warmup_count = '0;
        tail_count   = '0;
        ref_wait     = '0;
        prev_level   = LEVEL_FLOOR;
        prev_ref     = 1'b0;
    endfunction

    function automatic void apply_reg(input t_cfg_idx idx, input logic [10:0] data);
        case (idx)
            CFG_MIN_START_LEVEL: gate_cfg.min_start_level      = data;
            CFG_START_FRAMES:    gate_cfg.start_frames         = data[5:0];
            CFG_END_FRAMES:      gate_cfg.end_frames           = data[5:0];
            CFG_WARMUP_FRAMES:   gate_cfg.warmup_frames        = data[5:0];
            CFG_TAIL_FRAMES:     gate_cfg.tail_frames          = data[5:0];
            CFG_REF_WAIT_LIMIT:  gate_cfg.reference_wait_limit = data[7:0];
            default: ;
        endcase
    endfunction

    function automatic bit predict_gate_result(input t_in_item it, output t_out_item res);
        int   lvl_now;
        int   thr;
        logic ref_act, voiced, suppress, clear_vad;
        res = '0;
        if (it.operation == OP_ARM) begin
            session_on   = 1'b1;
            gate_armed   = 1'b1;
            bypass_on    = 1'b0;
            warmup_count = '0;
            ref_wait     = '0;
            tail_count   = '0;
            return 1'b0;
        end
        if (it.operation == OP_LISTENER_RESET) begin
            clear_speech();
            return 1'b0;
        end
        if (it.operation == OP_BREAK) begin
            if (session_on) begin
                gate_armed   = 1'b1;
                warmup_count = '0;
            end
            prev_level = LEVEL_FLOOR;
            prev_ref   = 1'b0;
            clear_speech();
            res.is_break          = 1'b1;
            res.vad_history_reset = 1'b1;
            return 1'b1;
        end

        ref_act  = prev_ref;
        lvl_now  = prev_level;
        thr      = gate_cfg.min_start_level;
        prev_ref = it.reference_now;
        voiced   = it.voice_detected && (speaking || lvl_now >= thr);
        if (voiced) begin
            if (voiced_streak < RUN_MAX) voiced_streak++;
            quiet_streak = '0;
        end else begin
            if (quiet_streak < RUN_MAX) quiet_streak++;
            voiced_streak = '0;
        end
        if (!speaking && voiced_streak >= gate_cfg.start_frames) begin
            speaking         = 1'b1;
            res.speech_start = 1'b1;
        end else if (speaking && quiet_streak >= gate_cfg.end_frames) begin
            speaking        = 1'b0;
            res.speech_stop = 1'b1;
        end
        prev_level = it.mic_level;

        suppress  = 1'b0;
        clear_vad = 1'b0;
        if (it.play_done) begin
            session_on   = 1'b0;
            gate_armed   = 1'b0;
            bypass_on    = 1'b0;
            warmup_count = '0;
            if (it.play_cut) begin
                tail_count = '0;
            end else begin
                tail_count = gate_cfg.tail_frames;
                suppress   = 1'b1;
            end
        end else if (bypass_on && it.output_audible) begin
            bypass_on  = 1'b0;
            gate_armed = 1'b1;
            ref_wait   = '0;
            suppress   = 1'b1;
        end else if (gate_armed) begin
            suppress = 1'b1;
            if (!it.render_started) begin
                ref_wait = '0;
            end else if (!it.output_audible) begin
                gate_armed = 1'b0;
                bypass_on  = 1'b1;
                ref_wait   = '0;
                suppress   = 1'b0;
            end else if (ref_act) begin
                gate_armed   = 1'b0;
                warmup_count = gate_cfg.warmup_frames;
                ref_wait     = '0;
            end else if (ref_wait < WAIT_MAX) begin
                ref_wait++;
                if (ref_wait == gate_cfg.reference_wait_limit)
                    res.reference_absent_warn = 1'b1;
            end
        end
        if (warmup_count != 0) begin
            suppress = 1'b1;
            warmup_count--;
            if (warmup_count == 0) clear_vad = 1'b1;
        end
        if (tail_count != 0) begin
            suppress = 1'b1;
            tail_count--;
            if (tail_count == 0) clear_vad = 1'b1;
        end
        if (clear_vad) clear_speech();

        res.vad_now           = voiced;
        res.voice_pass        = voiced && !suppress;
        res.ref_seen          = ref_act;
        res.input_level       = lvl_now[11:0];
        res.vad_history_reset = clear_vad;
        return 1'b1;
    endfunction

    function automatic int ref_gap();
        if ($urandom_range(9) == 0) return $urandom_range(250, 300);
        return $urandom_range(0, 40);
    endfunction

    function automatic t_in_item next_stimulus();
        t_in_item    it;
        logic [31:0] noise;
        int          pick;
        noise = $urandom;
        it    = noise[$bits(t_in_item)-1:0];
        pick  = $urandom_range(99);
        if (pick < 6) return it;
        if (pick < 9) begin
            it.operation = OP_BREAK;
            return it;
        end
        if (pick < 11) begin
            it.operation = OP_LISTENER_RESET;
            return it;
        end

        it.operation = OP_CAPTURE;
        if (speech_left == 0 && quiet_left == 0) begin
            speech_left = $urandom_range(1, 70);
            quiet_left  = $urandom_range(1, 70);
        end
        if (speech_left != 0) begin
            speech_left--;
            it.voice_detected = ($urandom_range(9) != 0);
        end else begin
            quiet_left--;
            it.voice_detected = ($urandom_range(9) == 0);
        end
        it.mic_level = it.voice_detected ? 12'(-int'($urandom_range(600)))
                                         : 12'(-int'($urandom_range(200, 1200)));
        it.reference_now = 1'b0;
        it.play_done     = 1'b0;

        case (pb_stage)
            PB_IDLE: begin
                it.reference_now = ($urandom_range(9) == 0);
                it.play_done     = ($urandom_range(49) == 0);
                if ($urandom_range(99) < 4) begin
                    it.operation = OP_ARM;
                    pb_stage     = PB_PRE_RENDER;
                    pb_left      = $urandom_range(4);
                end
            end
            PB_PRE_RENDER: begin
                it.render_started = 1'b0;
                if (pb_left != 0) begin
                    pb_left--;
                end else if ($urandom_range(4) == 0) begin
                    pb_stage = PB_MUTED;
                    pb_left  = $urandom_range(1, 10);
                end else begin
                    pb_stage = PB_AWAIT_REF;
                    pb_left  = ref_gap();
                end
            end
            PB_MUTED: begin
                it.render_started = 1'b1;
                it.output_audible = 1'b0;
                if (pb_left != 0) begin
                    pb_left--;
                end else begin
                    pb_stage = PB_AWAIT_REF;
                    pb_left  = ref_gap();
                end
            end
            PB_AWAIT_REF: begin
                it.render_started = 1'b1;
                it.output_audible = 1'b1;
                if (pb_left != 0) begin
                    pb_left--;
                end else begin
                    it.reference_now = 1'b1;
                    pb_stage         = PB_PLAYING;
                    pb_left          = $urandom_range(5, 80);
                end
            end
            default: begin
                it.render_started = 1'b1;
                it.output_audible = 1'b1;
                it.reference_now  = ($urandom_range(4) != 0);
                if (pb_left != 0) begin
                    pb_left--;
                end else begin
                    it.play_done = 1'b1;
                    pb_stage     = PB_IDLE;
                end
            end
        endcase
        return it;
    endfunction

    function automatic void choose_regs(input int phase);
        case (phase)
            0: reg_plan = '{11'(-900), 11'd1, 11'd1, 11'd0, 11'd0, 11'd1};
            1: reg_plan = '{11'd0, 11'd63, 11'd63, 11'd63, 11'd63, 11'd255};
            2: reg_plan = '{11'($urandom), {5'($urandom), 6'd0}, {5'($urandom), 6'd0},
                            11'($urandom), 11'($urandom), {3'($urandom), 8'd0}};
            default: reg_plan = '{11'(-int'($urandom_range(900))),
                                  11'($urandom_range(1, 8)),
                                  11'($urandom_range(1, 10)),
                                  11'($urandom_range(0, 12)),
                                  11'($urandom_range(0, 12)),
                                  11'($urandom_range(1, 30))};
        endcase
    endfunction

    task automatic program_regs(input logic [10:0] vals [6]);
        t_cfg_idx idx;
        idx = idx.first();
        repeat (idx.num()) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= vals[idx];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            apply_reg(idx, vals[idx]);
            idx = idx.next();
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_frame(input t_in_item it, input bit typed, input t_out_item want);
        t_out_item due;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (predict_gate_result(it, due)) results_due.push_back(typed ? want : due);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (results_due.size() == 0) begin
                $error("result beat with nothing due: %h", o_out_data);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                check_field("is_break", want.is_break, o_out_data.is_break);
                check_field("vad_now", want.vad_now, o_out_data.vad_now);
                check_field("speech_start", want.speech_start, o_out_data.speech_start);
                check_field("speech_stop", want.speech_stop, o_out_data.speech_stop);
                check_field("voice_pass", want.voice_pass, o_out_data.voice_pass);
                check_field("ref_seen", want.ref_seen, o_out_data.ref_seen);
                check_field("input_level", want.input_level, o_out_data.input_level);
                check_field("vad_history_reset", want.vad_history_reset,
                            o_out_data.vad_history_reset);
                check_field("reference_absent_warn", want.reference_absent_warn,
                            o_out_data.reference_absent_warn);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_in_item item;
        reset_gate_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        program_regs('{11'(-400), 11'd2, 11'd2, 11'd2, 11'd2, 11'd2});
        foreach (directed_rows[r]) begin
            item = {directed_rows[r].op, directed_rows[r].voice,
                    directed_rows[r].level, directed_rows[r].playback};
            send_frame(item, directed_rows[r].typed, directed_rows[r].want);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            choose_regs(phase);
            program_regs(reg_plan);
            tx_idle_pct = (phase < 3) ? 13 : (phase < 6) ? 85 : 0;
            rx_idle_pct = (phase < 3) ? 85 : (phase < 6) ? 13 : 0;
            // hold the result port so the input backs up
            if (phase == 6) rx_hold_req = 400;
            repeat ((phase == 1) ? 400 : 90) send_frame(next_stimulus(), 1'b0, '0);
        end
        drain_results();

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
